// ----- src/mbn_pkg.sv -----
// shared types and constants for the mesh bounding-box normalizer
package mbn_pkg;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 31;
    localparam int C2_W    = 33;   // doubled centre, min + max
    localparam int D2_W    = 34;   // 2*v - c2
    localparam int SIZE_W  = 32;   // box extent
    localparam int F_W     = 63;   // unsigned Q.32 scale factor
    localparam int Q_W     = 41;   // scaled offset, capped at 2^40
    localparam int S2_W    = 43;   // doubled result before rounding

    localparam logic [CFG_W-1:0]  TARGET_SIZE_RESET = 31'd8978;
    localparam logic [SIZE_W-1:0] SIZE_FLOOR        = 32'd6;
    localparam logic [Q_W-1:0]    Q_CAP             = 41'h100_0000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_vec lo;
        t_vec hi;
    } t_box;

    localparam t_vec VEC_LO_INIT = '{x: 32'sh7FFF_FFFF, y: 32'sh7FFF_FFFF, z: 32'sh7FFF_FFFF};
    localparam t_vec VEC_HI_INIT = '{x: 32'sh8000_0000, y: 32'sh8000_0000, z: 32'sh8000_0000};

endpackage

// ----- src/mesh_bbox_normalize.sv -----
// top level of the mesh bounding-box normalizer
// Vertices of one mesh (signed Q16.16) are taken at one per cycle unless o_stall
// is high and kept in a MAX_VERTICES-entry store; vertices beyond that are
// dropped. The beat marked final posts the mesh to the back end, which takes the
// job and finds the box size, then runs a one-bit-a-cycle divider for the scale
// factor (skipped when the larger xy extent is 6 raw units or less), and then
// emits one vertex per cycle, unless i_stall holds the output, through a 5-stage
// scaling pipeline. Vertices of the next mesh, its final beat included, are
// taken while the back end is still emitting, as long as each lands on a store
// entry already read out; once the next mesh is posted the input stalls until
// the back end has finished the current one and picked the next one up.
module mesh_bbox_normalize #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [mbn_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  mbn_pkg::t_coord            i_coord_x,
    input  mbn_pkg::t_coord            i_coord_y,
    input  mbn_pkg::t_coord            i_coord_z,
    input  logic                       i_is_final,
    output logic                       o_valid,
    input  logic                       i_stall,
    output mbn_pkg::t_coord            o_out_x,
    output mbn_pkg::t_coord            o_out_y,
    output mbn_pkg::t_coord            o_out_z,
    output logic                       o_end_of_mesh
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int JOB_W = CW + $bits(mbn_pkg::t_box);

    logic [mbn_pkg::CFG_W-1:0] r_target_size;

    mbn_pkg::t_vec  w_vtx;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    mbn_pkg::t_vec  w_wr_data;
    logic           w_push;
    mbn_pkg::t_box  w_push_box;
    logic [CW-1:0]  w_push_n;
    logic           w_q_valid;
    logic [JOB_W-1:0] w_q_data;
    logic           w_pop;
    logic           w_rd_busy;
    logic [CW-1:0]  w_rd_ptr;
    mbn_pkg::t_box  w_job_box;
    logic [CW-1:0]  w_job_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_size <= mbn_pkg::TARGET_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_target_size <= i_cfg_wr_data;
        end
    end

    assign w_vtx.x = i_coord_x;
    assign w_vtx.y = i_coord_y;
    assign w_vtx.z = i_coord_z;

    mbn_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .CW           (CW),
        .AW           (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_vtx      (w_vtx),
        .i_is_final (i_is_final),
        .i_q_busy   (w_q_valid),
        .i_rd_busy  (w_rd_busy),
        .i_rd_ptr   (w_rd_ptr),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_push     (w_push),
        .o_push_box (w_push_box),
        .o_push_n   (w_push_n)
    );

    mbn_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_n, w_push_box}),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_job_n   = w_q_data[JOB_W-1 -: CW];
    assign w_job_box = w_q_data[$bits(mbn_pkg::t_box)-1:0];

    mbn_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .CW           (CW),
        .AW           (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_target_size (r_target_size),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_data     (w_wr_data),
        .i_job_valid   (w_q_valid),
        .i_job_box     (w_job_box),
        .i_job_n       (w_job_n),
        .o_job_pop     (w_pop),
        .o_rd_busy     (w_rd_busy),
        .o_rd_ptr      (w_rd_ptr),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_x           (o_out_x),
        .o_y           (o_out_y),
        .o_z           (o_out_z),
        .o_end         (o_end_of_mesh)
    );

endmodule

// ----- src/mbn_queue.sv -----
// two-entry job queue between the front and the back
module mbn_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign w_push  = i_push && (r_count != 2'd2);
    assign w_pop   = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- src/mbn_front.sv -----
// front end: takes vertices, writes the store, tracks the box, posts a job per mesh
module mbn_front #(
    parameter int MAX_VERTICES = 64,
    parameter int CW           = 7,
    parameter int AW           = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mbn_pkg::t_vec     i_vtx,
    input  logic              i_is_final,
    input  logic              i_q_busy,
    input  logic              i_rd_busy,
    input  logic [CW-1:0]     i_rd_ptr,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output mbn_pkg::t_vec     o_wr_data,
    output logic              o_push,
    output mbn_pkg::t_box     o_push_box,
    output logic [CW-1:0]     o_push_n
);

    logic [CW-1:0]  r_total;
    mbn_pkg::t_vec  r_lo;
    mbn_pkg::t_vec  r_hi;
    logic [CW-1:0]  n_total;
    mbn_pkg::t_vec  n_lo;
    mbn_pkg::t_vec  n_hi;
    logic           w_room;
    logic           w_conflict;
    logic           w_accept;
    logic           w_store;

    assign w_room = (r_total < CW'(MAX_VERTICES));
    // the back still has to read this entry of the previous mesh
    assign w_conflict = i_rd_busy && w_room && (r_total >= i_rd_ptr);
    assign o_stall    = i_q_busy || w_conflict;
    assign w_accept   = i_valid && !o_stall;
    assign w_store    = w_accept && w_room;

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_total = r_total;
        if (w_store) begin
            n_total = r_total + 1'b1;
            if ($signed(i_vtx.x) < $signed(r_lo.x)) n_lo.x = i_vtx.x;
            if ($signed(i_vtx.y) < $signed(r_lo.y)) n_lo.y = i_vtx.y;
            if ($signed(i_vtx.z) < $signed(r_lo.z)) n_lo.z = i_vtx.z;
            if ($signed(i_vtx.x) > $signed(r_hi.x)) n_hi.x = i_vtx.x;
            if ($signed(i_vtx.y) > $signed(r_hi.y)) n_hi.y = i_vtx.y;
            if ($signed(i_vtx.z) > $signed(r_hi.z)) n_hi.z = i_vtx.z;
        end
    end

    assign o_wr_en       = w_store;
    assign o_wr_addr     = r_total[AW-1:0];
    assign o_wr_data     = i_vtx;
    assign o_push        = w_accept && i_is_final;
    assign o_push_box.lo = n_lo;
    assign o_push_box.hi = n_hi;
    assign o_push_n      = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_total <= '0;
            r_lo    <= mbn_pkg::VEC_LO_INIT;
            r_hi    <= mbn_pkg::VEC_HI_INIT;
        end else begin
            r_total <= n_total;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
        end
    end

endmodule

// ----- src/mbn_lane.sv -----
// one axis of the scaling pipeline: offset, split multiply, cap, round, saturate
module mbn_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  mbn_pkg::t_coord             i_v,
    input  logic signed [mbn_pkg::C2_W-1:0] i_c2,
    input  logic [mbn_pkg::F_W-1:0]     i_f,
    input  logic                        i_plain,
    output mbn_pkg::t_coord             o_res
);

    // stage 1
    mbn_pkg::t_coord                    r_raw1;
    logic [mbn_pkg::D2_W-1:0]           r_mag1;
    logic                               r_neg1;
    logic signed [mbn_pkg::C2_W-1:0]    r_c2_1;
    // stage 2
    mbn_pkg::t_coord                    r_raw2;
    logic [63:0]                        r_p00;
    logic [62:0]                        r_p01;
    logic [33:0]                        r_p10;
    logic                               r_cap2;
    logic                               r_neg2;
    logic signed [mbn_pkg::C2_W-1:0]    r_c2_2;
    // stage 3
    mbn_pkg::t_coord                    r_raw3;
    logic [mbn_pkg::Q_W-1:0]            r_q3;
    logic                               r_neg3;
    logic signed [mbn_pkg::C2_W-1:0]    r_c2_3;
    // stage 4
    mbn_pkg::t_coord                    r_res;

    logic signed [mbn_pkg::D2_W-1:0]    w_d2;
    logic [32:0]                        w_rnd;
    logic [63:0]                        w_sum;
    logic [mbn_pkg::Q_W-1:0]            w_q;
    logic signed [mbn_pkg::S2_W-1:0]    w_c2e;
    logic signed [mbn_pkg::S2_W-1:0]    w_qe;
    logic signed [mbn_pkg::S2_W-1:0]    w_t;
    logic signed [mbn_pkg::S2_W-2:0]    w_r;
    mbn_pkg::t_coord                    w_sat;

    assign w_d2 = $signed({i_v[31], i_v, 1'b0}) - $signed({i_c2[32], i_c2});

    // rounded high part of a0*f0, plus the cross products
    assign w_rnd = 33'(({1'b0, r_p00} + 65'h0_8000_0000) >> 32);
    assign w_sum = 64'(r_p01) + 64'(r_p10) + 64'(w_rnd);
    assign w_q   = (r_cap2 || (w_sum > 64'(mbn_pkg::Q_CAP))) ? mbn_pkg::Q_CAP
                                                             : w_sum[mbn_pkg::Q_W-1:0];

    assign w_c2e = mbn_pkg::S2_W'(r_c2_3);
    assign w_qe  = $signed({2'b00, r_q3});
    // doubled result plus one, then halved: ties round upward
    assign w_t   = r_neg3 ? (w_c2e - w_qe + 43'sd1) : (w_c2e + w_qe + 43'sd1);
    assign w_r   = w_t[mbn_pkg::S2_W-1:1];

    always_comb begin
        priority if (w_r > 42'sh0_007F_FFFF_FF) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_r < -42'sh0_0080_0000_00) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw1 <= i_v;
            r_neg1 <= w_d2[mbn_pkg::D2_W-1];
            r_mag1 <= w_d2[mbn_pkg::D2_W-1] ? 34'(-w_d2) : 34'(w_d2);
            r_c2_1 <= i_c2;

            r_raw2 <= r_raw1;
            r_p00  <= 64'(r_mag1[31:0]) * 64'(i_f[31:0]);
            r_p01  <= 63'(r_mag1[31:0]) * 63'(i_f[62:32]);
            r_p10  <= 34'(r_mag1[33:32]) * 34'(i_f[31:0]);
            r_cap2 <= (r_mag1[33:32] != 2'd0) && (i_f[62:32] != 31'd0);
            r_neg2 <= r_neg1;
            r_c2_2 <= r_c2_1;

            r_raw3 <= r_raw2;
            r_q3   <= w_q;
            r_neg3 <= r_neg2;
            r_c2_3 <= r_c2_2;

            r_res  <= i_plain ? r_raw3 : w_sat;
        end
    end

    assign o_res = r_res;

endmodule

// ----- src/mbn_back.sv -----
// back end: box size, factor divider, vertex store and the emit pipeline
module mbn_back #(
    parameter int MAX_VERTICES = 64,
    parameter int CW           = 7,
    parameter int AW           = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mbn_pkg::CFG_W-1:0]     i_target_size,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  mbn_pkg::t_vec                 i_wr_data,
    input  logic                          i_job_valid,
    input  mbn_pkg::t_box                 i_job_box,
    input  logic [CW-1:0]                 i_job_n,
    output logic                          o_job_pop,
    output logic                          o_rd_busy,
    output logic [CW-1:0]                 o_rd_ptr,
    output logic                          o_valid,
    input  logic                          i_stall,
    output mbn_pkg::t_coord               o_x,
    output mbn_pkg::t_coord               o_y,
    output mbn_pkg::t_coord               o_z,
    output logic                          o_end
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SIZE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [5:0] DIV_LAST = 6'(mbn_pkg::F_W - 1);

    logic [2:0]                         r_state;
    logic [CW-1:0]                      r_n;
    logic [CW-1:0]                      r_rd_ptr;
    logic signed [mbn_pkg::C2_W-1:0]    r_c2x;
    logic signed [mbn_pkg::C2_W-1:0]    r_c2y;
    logic signed [mbn_pkg::C2_W-1:0]    r_c2z;
    logic [mbn_pkg::SIZE_W-1:0]         r_ex;
    logic [mbn_pkg::SIZE_W-1:0]         r_ey;
    logic [mbn_pkg::SIZE_W-1:0]         r_size;
    logic                               r_plain;
    logic [mbn_pkg::SIZE_W-1:0]         r_rem;
    logic [mbn_pkg::F_W-1:0]            r_quo;
    logic [5:0]                         r_cnt;
    logic [4:0]                         r_vld;
    logic [4:0]                         r_last;
    mbn_pkg::t_vec                      r_mem [MAX_VERTICES];
    mbn_pkg::t_vec                      r_rd_data;

    logic                               w_en;
    logic                               w_issue;
    logic                               w_more;
    logic                               w_pipe_empty;
    logic [mbn_pkg::SIZE_W:0]           w_rem_sh;
    logic [mbn_pkg::SIZE_W+1:0]         w_diff;
    logic                               w_ge;
    logic [mbn_pkg::C2_W-1:0]           w_ex;
    logic [mbn_pkg::C2_W-1:0]           w_ey;

    function automatic logic [mbn_pkg::C2_W-1:0] C2W_SUB(mbn_pkg::t_coord a,
                                                          mbn_pkg::t_coord b);
        C2W_SUB = {a[31], a} - {b[31], b};
    endfunction

    assign w_en         = !r_vld[4] || !i_stall;
    assign w_more       = (r_rd_ptr != r_n);
    assign w_issue      = w_en && (r_state == ST_EMIT) && w_more;
    assign w_pipe_empty = (r_vld[3:0] == 4'd0);

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign o_rd_busy = (r_state == ST_SIZE) || (r_state == ST_CHECK) || (r_state == ST_DIV)
                     || ((r_state == ST_EMIT) && w_more);
    assign o_rd_ptr  = r_rd_ptr;

    assign w_ex = C2W_SUB(i_job_box.hi.x, i_job_box.lo.x);
    assign w_ey = C2W_SUB(i_job_box.hi.y, i_job_box.lo.y);

    // restoring divider, one quotient bit a cycle
    assign w_rem_sh = {r_rem, r_quo[mbn_pkg::F_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_size};
    assign w_ge     = !w_diff[mbn_pkg::SIZE_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_ptr <= '0;
            r_n      <= '0;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_n      <= i_job_n;
                        r_rd_ptr <= '0;
                        r_c2x    <= $signed({i_job_box.lo.x[31], i_job_box.lo.x})
                                  + $signed({i_job_box.hi.x[31], i_job_box.hi.x});
                        r_c2y    <= $signed({i_job_box.lo.y[31], i_job_box.lo.y})
                                  + $signed({i_job_box.hi.y[31], i_job_box.hi.y});
                        r_c2z    <= $signed({i_job_box.lo.z[31], i_job_box.lo.z})
                                  + $signed({i_job_box.hi.z[31], i_job_box.hi.z});
                        r_ex     <= w_ex[mbn_pkg::SIZE_W-1:0];
                        r_ey     <= w_ey[mbn_pkg::SIZE_W-1:0];
                        r_state  <= ST_SIZE;
                    end
                end
                ST_SIZE: begin
                    r_size  <= (r_ex > r_ey) ? r_ex : r_ey;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_plain <= (r_size <= mbn_pkg::SIZE_FLOOR);
                    r_rem   <= '0;
                    r_quo   <= {i_target_size, 32'd0};
                    r_cnt   <= '0;
                    r_state <= (r_size <= mbn_pkg::SIZE_FLOOR) ? ST_EMIT : ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= w_ge ? w_diff[mbn_pkg::SIZE_W-1:0] : w_rem_sh[mbn_pkg::SIZE_W-1:0];
                    r_quo <= {r_quo[mbn_pkg::F_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_issue) begin
                        r_rd_ptr <= r_rd_ptr + 1'b1;
                    end
                    // factor and centre stay put until the lanes have drained
                    if (!w_more && w_pipe_empty) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd_data <= r_mem[r_rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], w_issue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[3:0], (CW'(r_rd_ptr + 1'b1) == r_n)};
        end
    end

    mbn_lane u_lane_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_v     (r_rd_data.x),
        .i_c2    (r_c2x),
        .i_f     (r_quo),
        .i_plain (r_plain),
        .o_res   (o_x)
    );

    mbn_lane u_lane_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_v     (r_rd_data.y),
        .i_c2    (r_c2y),
        .i_f     (r_quo),
        .i_plain (r_plain),
        .o_res   (o_y)
    );

    mbn_lane u_lane_z (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_v     (r_rd_data.z),
        .i_c2    (r_c2z),
        .i_f     (r_quo),
        .i_plain (r_plain),
        .o_res   (o_z)
    );

    assign o_valid = r_vld[4];
    assign o_end   = r_last[4];

endmodule

// ----- src/mbn_checker.sv -----
// port-level checks for the mesh bounding-box normalizer, bound to the top level
module mbn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_is_final,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_x,
    input logic [31:0] o_out_y,
    input logic [31:0] o_out_z,
    input logic        o_end_of_mesh
);

    // reset leaves no result pending and the input open
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
                               && $stable(o_out_z) && $stable(o_end_of_mesh))
        else $error("stalled result beat changed");

    // a posted mesh blocks the input until the back end picks it up
    a_final_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_final |=> o_stall)
        else $error("input open in the cycle after a final beat");

    // the next mesh cannot follow its predecessor's last beat directly
    a_mesh_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_end_of_mesh |=> !o_valid)
        else $error("result right after the end of a mesh");

endmodule

bind mesh_bbox_normalize mbn_checker u_mbn_checker (.*);

// ----- dv/tb.sv -----
// self-checking testbench for the mesh bounding-box normalizer
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              STORE_DEPTH      = 64;
    localparam int              TARGET_W         = mbn_pkg::CFG_W;
    localparam int              SETTLE_CYCLES    = 100;
    localparam int              TAIL_CYCLES      = 150;
    localparam int              LONG_HOLD_CYCLES = 600;
    localparam int              MAX_PRINTED      = 100;
    localparam int              PHASE_ITEMS      = 55;
    localparam mbn_pkg::t_coord COORD_MIN        = 32'sh8000_0000;
    localparam mbn_pkg::t_coord COORD_MAX        = 32'sh7FFF_FFFF;

    typedef struct {
        mbn_pkg::t_coord x;
        mbn_pkg::t_coord y;
        mbn_pkg::t_coord z;
        logic            eom;
    } t_norm_vertex;

    // mirrors the mesh store and box, predicts the normalized vertices
    class mesh_scoreboard;
        mbn_pkg::t_coord       verts [STORE_DEPTH][3];
        int unsigned           vert_count;
        mbn_pkg::t_coord       lo [3];
        mbn_pkg::t_coord       hi [3];
        logic [TARGET_W-1:0]   target;
        t_norm_vertex          expected_q [$];
        int                    errors;

        function new();
            target = mbn_pkg::TARGET_SIZE_RESET;
            errors = 0;
            clear_box();
        endfunction

        function void clear_box();
            vert_count = 0;
            for (int a = 0; a < 3; a++) begin
                lo[a] = COORD_MAX;
                hi[a] = COORD_MIN;
            end
        endfunction

        function void set_target(logic [TARGET_W-1:0] value);
            target = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            // keep the log short when the design is badly broken
            if (errors <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // centre + (v - centre) * factor, all in doubled units, rounded and saturated
        function mbn_pkg::t_coord scale_axis(mbn_pkg::t_coord v, longint c2,
                                             logic [63:0] factor);
            longint      d2;
            longint      s2;
            longint      r;
            logic [63:0] mag;
            logic [63:0] a0;
            logic [63:0] a1;
            logic [63:0] f0;
            logic [63:0] f1;
            logic [63:0] q;
            logic [63:0] cap;
            cap = 64'(mbn_pkg::Q_CAP);
            d2  = 2 * longint'(v) - c2;
            mag = (d2 < 0) ? -d2 : d2;
            a0  = {32'd0, mag[31:0]};
            a1  = mag >> 32;
            f0  = {32'd0, factor[31:0]};
            f1  = factor >> 32;
            if (a1 != 0 && f1 != 0) begin
                q = cap;
            end else begin
                q = a1 * f0 + a0 * f1 + ((a0 * f0 + 64'h8000_0000) >> 32);
                if (q > cap)
                    q = cap;
            end
            s2 = (d2 < 0) ? c2 - longint'(q) : c2 + longint'(q);
            r  = (s2 + 1) >>> 1;
            if (r > longint'(COORD_MAX))
                r = longint'(COORD_MAX);
            if (r < longint'(COORD_MIN))
                r = longint'(COORD_MIN);
            return r[31:0];
        endfunction

        function void note_vertex(mbn_pkg::t_coord x, mbn_pkg::t_coord y,
                                  mbn_pkg::t_coord z, logic fin);
            mbn_pkg::t_coord v [3];
            longint          c2 [3];
            longint          ex;
            longint          ey;
            longint          size;
            logic [63:0]     factor;
            logic            plain;
            t_norm_vertex    e;
            mbn_pkg::t_coord r [3];
            v[0] = x;
            v[1] = y;
            v[2] = z;
            // a full store drops the beat, box untouched
            if (vert_count < STORE_DEPTH) begin
                for (int a = 0; a < 3; a++) begin
                    verts[vert_count][a] = v[a];
                    if (v[a] < lo[a])
                        lo[a] = v[a];
                    if (v[a] > hi[a])
                        hi[a] = v[a];
                end
                vert_count++;
            end
            if (!fin)
                return;
            for (int a = 0; a < 3; a++)
                c2[a] = longint'(lo[a]) + longint'(hi[a]);
            ex     = longint'(hi[0]) - longint'(lo[0]);
            ey     = longint'(hi[1]) - longint'(lo[1]);
            size   = (ex > ey) ? ex : ey;
            plain  = size <= longint'(mbn_pkg::SIZE_FLOOR);
            factor = plain ? 64'd0 : {1'b0, target, 32'd0} / 64'(size);
            for (int k = 0; k < vert_count; k++) begin
                for (int a = 0; a < 3; a++)
                    r[a] = plain ? verts[k][a] : scale_axis(verts[k][a], c2[a], factor);
                e.x   = r[0];
                e.y   = r[1];
                e.z   = r[2];
                e.eom = (k + 1 == vert_count);
                expected_q = {expected_q, e};
            end
            clear_box();
        endfunction

        task check_result(mbn_pkg::t_coord x, mbn_pkg::t_coord y, mbn_pkg::t_coord z,
                          logic eom);
            t_norm_vertex e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected vertex out (%h %h %h eom %b)", x, y, z, eom));
                return;
            end
            e = expected_q.pop_front();
            if (x !== e.x)
                report($sformatf("out_x got %h exp %h", x, e.x));
            if (y !== e.y)
                report($sformatf("out_y got %h exp %h", y, e.y));
            if (z !== e.z)
                report($sformatf("out_z got %h exp %h", z, e.z));
            if (eom !== e.eom)
                report($sformatf("end_of_mesh got %b exp %b", eom, e.eom));
        endtask
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [TARGET_W-1:0] i_cfg_wr_data = '0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    mbn_pkg::t_coord     i_coord_x     = '0;
    mbn_pkg::t_coord     i_coord_y     = '0;
    mbn_pkg::t_coord     i_coord_z     = '0;
    logic                i_is_final    = 1'b0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    mbn_pkg::t_coord     o_out_x;
    mbn_pkg::t_coord     o_out_y;
    mbn_pkg::t_coord     o_out_z;
    logic                o_end_of_mesh;

    mesh_scoreboard   sb;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    logic             long_hold     = 1'b0;
    event             hold_go;

    mesh_bbox_normalize #(
        .MAX_VERTICES (STORE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_is_final    (i_is_final),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_end_of_mesh (o_end_of_mesh)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: check accepted beats, pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_x, o_out_y, o_out_z, o_end_of_mesh);
        i_stall <= long_hold || ($urandom_range(99) < stall_pct);
    end

    // long output hold-off, counted here while the sender keeps going
    initial forever begin
        @(hold_go);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_vertex(input mbn_pkg::t_coord x, input mbn_pkg::t_coord y,
                               input mbn_pkg::t_coord z, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_coord_x  <= x;
        i_coord_y  <= y;
        i_coord_z  <= z;
        i_is_final <= fin;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_vertex(x, y, z, fin);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic finish_phase();
        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.set_target(value);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic mbn_pkg::t_coord extreme_coord();
        case ($urandom_range(5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_mesh(output int n);
        int              pick;
        int              shape;
        int unsigned     span;
        mbn_pkg::t_coord base [3];
        mbn_pkg::t_coord c [3];
        pick = $urandom_range(99);
        if (pick < 3)
            n = $urandom_range(65, 72);   // overruns the store
        else if (pick < 13)
            n = $urandom_range(13, 64);
        else
            n = $urandom_range(1, 12);
        shape = $urandom_range(3);
        span  = 32'h1 << $urandom_range(31);
        for (int a = 0; a < 3; a++)
            base[a] = $urandom;
        for (int k = 0; k < n; k++) begin
            for (int a = 0; a < 3; a++) begin
                case (shape)
                    0: c[a] = $urandom;
                    1: c[a] = base[a] + $urandom_range(span);
                    // extents straddle the small-size threshold
                    2: c[a] = base[a] + $urandom_range(7);
                    default: c[a] = extreme_coord();
                endcase
            end
            send_vertex(c[0], c[1], c[2], k == n - 1);
        end
    endtask

    task automatic run_meshes(input int budget, input int pause_at);
        int sent;
        int n;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget) begin
            send_random_mesh(n);
            sent += n;
            if (pause_at > 0 && sent >= pause_at && !paused) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                wait_drained();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed meshes at the reset target size
        send_vertex(COORD_MAX, COORD_MIN, 32'sd0, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        // extent of exactly 6 stays unscaled, 7 gets scaled
        send_vertex(32'sd0, 32'sd0, -32'sd100, 1'b0);
        send_vertex(32'sd6, 32'sd2, 32'sd100, 1'b1);
        send_vertex(-32'sd3, -32'sd3, 32'sd1, 1'b0);
        send_vertex(32'sd4, 32'sd0, 32'sd2, 1'b1);
        // y extent dominates
        send_vertex(32'sd10, 32'sd0, 32'sd0, 1'b0);
        send_vertex(32'sd20, 32'sd500000, -32'sd7, 1'b0);
        send_vertex(32'sd15, -32'sd500000, 32'sd7, 1'b1);
        send_vertex(32'sd65536, -32'sd65536, 32'sd131072, 1'b0);
        send_vertex(-32'sd32768, 32'sd98304, 32'sd0, 1'b0);
        send_vertex(32'sd1, 32'sd2, 32'sd3, 1'b0);
        send_vertex(-32'sd1, -32'sd2, -32'sd3, 1'b1);
        // huge z extent but tiny xy box: passes through unchanged
        send_vertex(32'sd0, 32'sd0, COORD_MIN, 1'b0);
        send_vertex(32'sd1, 32'sd1, COORD_MAX, 1'b1);
        finish_phase();

        // largest target, store overrun with the final beat dropped
        write_target(31'h7FFF_FFFF);
        for (int k = 0; k < 70; k++)
            send_vertex($urandom, $urandom, $urandom, k == 69);
        run_meshes(PHASE_ITEMS, 0);
        finish_phase();

        write_target(31'd0);
        send_idle_pct = 76;
        run_meshes(PHASE_ITEMS, 35);
        finish_phase();

        write_target(31'd65536);
        send_idle_pct = 0;
        stall_pct     = 76;
        run_meshes(PHASE_ITEMS, 0);
        finish_phase();

        write_target(TARGET_W'($urandom));
        send_idle_pct = 9;
        stall_pct     = 9;
        run_meshes(PHASE_ITEMS, 0);
        finish_phase();

        // output held off long enough to back up the input side
        write_target(TARGET_W'($urandom_range(1 << 20)));
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_go;
        run_meshes(PHASE_ITEMS, 0);

        i_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- mesh_bbox_normalize.f -----
src/mbn_pkg.sv
src/mbn_queue.sv
src/mbn_front.sv
src/mbn_lane.sv
src/mbn_back.sv
src/mesh_bbox_normalize.sv
src/mbn_checker.sv
dv/tb.sv
